FILE: hdl/ptts_pkg.sv
package ptts_pkg;

  localparam int OP_W   = 3;
  localparam int ID_W   = 3;
  localparam int IN_W   = 16;
  localparam int MASK_W = 8;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_TICK    = 3'd0;
  localparam op_t OP_CREATE  = 3'd1;
  localparam op_t OP_SUSPEND = 3'd2;
  localparam op_t OP_RESUME  = 3'd3;
  localparam op_t OP_DELETE  = 3'd4;

endpackage

FILE: hdl/ptts_mem.sv
module ptts_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ptts_dec.sv
module ptts_dec #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] count,
  input  logic [WIDTH-1:0] period,
  output logic             fire,
  output logic [WIDTH-1:0] count_next
);

  logic [WIDTH-1:0] operand;

  // one decrementer serves both the reload and the countdown
  assign fire       = (count == '0);
  assign operand    = fire ? period : count;
  assign count_next = operand - WIDTH'(1);

endmodule

FILE: hdl/periodic_task_tick_scheduler_top.sv
// Periodic task scheduler over a table of NUM_TASKS slots. Every accepted
// transaction yields exactly one fired_mask result. For create, suspend, resume
// and delete the result is offered on the cycle after acceptance. A tick walks
// the table one slot per cycle through a single decrementer, with countdown and
// period kept in single-port-read memories, and its result is registered in the
// DRAIN state that follows the walk. The block takes one transaction at a time
// and accepts the next once the pending result is taken (or is being taken in
// the same cycle). No clearing pass is needed after reset.
module periodic_task_tick_scheduler_top #(
  parameter int NUM_TASKS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [2:0]  task_id,
  input  logic [15:0] period,
  input  logic [15:0] first_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  fired_mask
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int EXT_W = IDX_W + ptts_pkg::ID_W;
  localparam int CW    = COUNT_BITS;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DRAIN
  } state_t;

  state_t                      state;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            pidx;
  logic                        pvalid;
  logic [ptts_pkg::MASK_W-1:0] mask;
  logic [ptts_pkg::MASK_W-1:0] mask_next;
  logic [NUM_TASKS-1:0]        present;
  logic [NUM_TASKS-1:0]        ready;

  logic                        in_fire;
  logic                        id_ok;
  logic [EXT_W-1:0]            id_ext;
  logic [IDX_W-1:0]            id_addr;
  logic [EXT_W-1:0]            pidx_ext;
  logic [CW+15:0]              per_ext;
  logic [CW+15:0]              dly_ext;

  logic                        active;
  logic                        dec_fire;
  logic [CW-1:0]               dec_next;
  logic [CW-1:0]               cnt_rdata;
  logic [CW-1:0]               per_rdata;
  logic                        cnt_we;
  logic [IDX_W-1:0]            cnt_waddr;
  logic [CW-1:0]               cnt_wdata;
  logic                        per_we;

  assign in_ready = (state == IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign id_ext   = EXT_W'(task_id);
  assign id_ok    = id_ext < EXT_W'(NUM_TASKS);
  assign id_addr  = id_ext[IDX_W-1:0];
  assign pidx_ext = EXT_W'(pidx);
  assign per_ext  = (CW + 16)'(period);
  assign dly_ext  = (CW + 16)'(first_delay);

  assign active = pvalid && present[pidx] && ready[pidx];

  ptts_dec #(
    .WIDTH (CW)
  ) u_dec (
    .count      (cnt_rdata),
    .period     (per_rdata),
    .fire       (dec_fire),
    .count_next (dec_next)
  );

  always_comb begin
    mask_next = mask;
    if (active && dec_fire && (pidx_ext < EXT_W'(ptts_pkg::MASK_W))) begin
      mask_next = mask | (ptts_pkg::MASK_W'(1) << pidx_ext[2:0]);
    end
  end

  // create writes in idle; the walk writes back the slot read last cycle
  assign per_we = in_fire && id_ok && (op == ptts_pkg::OP_CREATE);

  always_comb begin
    if (state == IDLE) begin
      cnt_we    = per_we;
      cnt_waddr = id_addr;
      cnt_wdata = dly_ext[CW-1:0];
    end else begin
      cnt_we    = active;
      cnt_waddr = pidx;
      cnt_wdata = dec_next;
    end
  end

  ptts_mem #(
    .DEPTH (NUM_TASKS),
    .WIDTH (CW),
    .AW    (IDX_W)
  ) u_cnt_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (idx),
    .rdata (cnt_rdata)
  );

  ptts_mem #(
    .DEPTH (NUM_TASKS),
    .WIDTH (CW),
    .AW    (IDX_W)
  ) u_per_mem (
    .clk   (clk),
    .we    (per_we),
    .waddr (id_addr),
    .wdata (per_ext[CW-1:0]),
    .raddr (idx),
    .rdata (per_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      ready   <= '0;
    end else if (in_fire && id_ok) begin
      unique case (op)
        ptts_pkg::OP_CREATE: begin
          present[id_addr] <= 1'b1;
          ready[id_addr]   <= 1'b1;
        end
        ptts_pkg::OP_SUSPEND: ready[id_addr]   <= 1'b0;
        ptts_pkg::OP_RESUME:  ready[id_addr]   <= 1'b1;
        ptts_pkg::OP_DELETE:  present[id_addr] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      pidx      <= '0;
      pvalid    <= 1'b0;
      mask      <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            if (op == ptts_pkg::OP_TICK) begin
              // any pending result is being taken in this cycle
              out_valid <= 1'b0;
              state     <= WALK;
              idx       <= '0;
              pvalid    <= 1'b0;
              mask      <= '0;
            end else begin
              out_valid  <= 1'b1;
              fired_mask <= '0;
            end
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        WALK: begin
          pvalid <= 1'b1;
          pidx   <= idx;
          mask   <= mask_next;
          if (idx == IDX_W'(NUM_TASKS - 1)) begin
            state <= DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        DRAIN: begin
          pvalid     <= 1'b0;
          out_valid  <= 1'b1;
          fired_mask <= mask_next;
          state      <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: verif/periodic_task_tick_scheduler_checker.sv
module periodic_task_tick_scheduler_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ptts_pkg::op_t  op,
  input  logic [2:0]     task_id,
  input  logic [15:0]    period,
  input  logic [15:0]    first_delay,
  input  logic           out_valid,
  input  logic           out_ready,
  input  logic [7:0]     fired_mask,
  output int             mismatch_count,
  output int             expected_left,
  output int             fired_total,
  output int             result_total
);

  localparam int SLOTS = 8;

  logic [SLOTS-1:0] slot_present;
  logic [SLOTS-1:0] slot_ready;
  logic [15:0]      slot_count [SLOTS];
  logic [15:0]      slot_period[SLOTS];
  logic [7:0]       fired_q[$];

  // advances the task table by one transaction, returns the fired slots
  function automatic logic [7:0] schedule_step(ptts_pkg::op_t o, logic [2:0] id,
                                               logic [15:0] p, logic [15:0] d);
    logic [7:0] fired;
    fired = '0;
    case (o)
      ptts_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_present[i] && slot_ready[i]) begin
            if (slot_count[i] == '0) begin
              fired[i] = 1'b1;
              slot_count[i] = slot_period[i] - 16'd1;
            end else begin
              slot_count[i] = slot_count[i] - 16'd1;
            end
          end
        end
      end
      ptts_pkg::OP_CREATE: begin
        slot_period[id] = p;
        slot_count[id] = d;
        slot_present[id] = 1'b1;
        slot_ready[id] = 1'b1;
      end
      ptts_pkg::OP_SUSPEND: slot_ready[id] = 1'b0;
      ptts_pkg::OP_RESUME: slot_ready[id] = 1'b1;
      ptts_pkg::OP_DELETE: slot_present[id] = 1'b0;
      default: ;
    endcase
    return fired;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (rst) begin
      slot_present = '0;
      slot_ready = '0;
      fired_q.delete();
      mismatch_count <= 0;
      expected_left <= 0;
      fired_total <= 0;
      result_total <= 0;
    end else begin
      // result side first: a result never leaves in the cycle its transaction enters
      if (out_valid && out_ready) begin
        result_total <= result_total + 1;
        if (fired_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: fired_mask result with nothing expected, actual %02h",
                     $realtime, fired_mask);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = fired_q.pop_front();
          if (fired_mask !== want) begin
            if (mismatch_count < 10)
              $display("%0t: fired_mask mismatch, expected %02h actual %02h",
                       $realtime, want, fired_mask);
            mismatch_count <= mismatch_count + 1;
          end
          fired_total <= fired_total + $countones(want);
        end
      end
      if (in_valid && in_ready)
        fired_q.push_back(schedule_step(op, task_id, period, first_delay));
      expected_left <= fired_q.size();
    end
  end

endmodule

FILE: verif/periodic_task_tick_scheduler_top_tb.sv
module periodic_task_tick_scheduler_top_tb;

  localparam ptts_pkg::op_t OP_SPARE_FIRST = ptts_pkg::OP_DELETE + 3'd1;
  localparam ptts_pkg::op_t OP_SPARE_LAST  = '1;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  ptts_pkg::op_t op = ptts_pkg::OP_TICK;
  logic [2:0]    task_id = '0;
  logic [15:0]   period = '0;
  logic [15:0]   first_delay = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [7:0]    fired_mask;

  int mismatch_count;
  int expected_left;
  int fired_total;
  int result_total;

  logic quiet = 1'b0;
  int   stall_left = 0;
  int   sent_total = 0;
  int   tick_total = 0;
  int   create_total = 0;

  always #1 clk = ~clk;

  periodic_task_tick_scheduler_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .task_id    (task_id),
    .period     (period),
    .first_delay(first_delay),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired_mask (fired_mask)
  );

  periodic_task_tick_scheduler_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .task_id       (task_id),
    .period        (period),
    .first_delay   (first_delay),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired_mask    (fired_mask),
    .mismatch_count(mismatch_count),
    .expected_left (expected_left),
    .fired_total   (fired_total),
    .result_total  (result_total)
  );

  // result back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 14);
    end
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_op(ptts_pkg::op_t o, logic [2:0] id, logic [15:0] p,
                         logic [15:0] d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    task_id <= id;
    period <= p;
    first_delay <= d;
    do @(posedge clk); while (!in_ready);
    sent_total++;
    if (o == ptts_pkg::OP_TICK) tick_total++;
    if (o == ptts_pkg::OP_CREATE) create_total++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int pick;
    logic [15:0] p;
    logic [15:0] d;
    pick = $urandom_range(0, 99);
    p = 16'($urandom_range(0, 16'hffff));
    d = 16'($urandom_range(0, 16'hffff));
    if (pick < 45) begin
      send_op(ptts_pkg::OP_TICK, 3'($urandom_range(0, 7)), p, d);
    end else if (pick < 65) begin
      // mostly short periods so slots fire often
      if ($urandom_range(0, 7) != 0) begin
        p = 16'($urandom_range(0, 6));
        d = 16'($urandom_range(0, 8));
      end
      send_op(ptts_pkg::OP_CREATE, 3'($urandom_range(0, 7)), p, d);
    end else if (pick < 73) begin
      send_op(ptts_pkg::OP_SUSPEND, 3'($urandom_range(0, 7)), p, d);
    end else if (pick < 81) begin
      send_op(ptts_pkg::OP_RESUME, 3'($urandom_range(0, 7)), p, d);
    end else if (pick < 89) begin
      send_op(ptts_pkg::OP_DELETE, 3'($urandom_range(0, 7)), p, d);
    end else if (pick < 92) begin
      send_op(ptts_pkg::op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
              3'($urandom_range(0, 7)), p, d);
    end else begin
      send_op(ptts_pkg::OP_TICK, 3'($urandom_range(0, 7)), p, d);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_CREATE, 3'd0, 16'd1, 16'h0000);
    send_op(ptts_pkg::OP_CREATE, 3'd7, 16'h0000, 16'h0000);  // period zero reloads all ones
    send_op(ptts_pkg::OP_CREATE, 3'd3, 16'hffff, 16'hffff);
    send_op(ptts_pkg::OP_CREATE, 3'd5, 16'd2, 16'd1);
    send_op(ptts_pkg::OP_TICK, 3'd7, 16'hffff, 16'hffff);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_SUSPEND, 3'd5, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_RESUME, 3'd5, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_SUSPEND, 3'd2, 16'h0000, 16'h0000);    // absent slot
    send_op(ptts_pkg::OP_RESUME, 3'd4, 16'h0000, 16'h0000);     // absent slot stays idle
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_DELETE, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_CREATE, 3'd0, 16'd3, 16'd2);
    send_op(ptts_pkg::OP_CREATE, 3'd7, 16'haaaa, 16'h5555);     // overwrite a live slot
    send_op(OP_SPARE_FIRST, 3'd1, 16'd9, 16'd0);
    send_op(OP_SPARE_FIRST + 3'd1, 3'd6, 16'h5555, 16'haaaa);
    send_op(OP_SPARE_LAST, 3'd2, 16'hffff, 16'hffff);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_op(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    drain_results();

    for (int i = 0; i < 400; i++) begin
      if (i == 200) drain_results();
      if (i == 340) quiet <= 1'b1;
      send_random_op();
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d transactions: %0d ticks, %0d creates, rest flag changes and unused ops",
             sent_total, tick_total, create_total);
    $display("checked %0d fired_mask results with %0d task firings", result_total, fired_total);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("[periodic_task_tick_scheduler_top] OK");
    end else begin
      $display("[periodic_task_tick_scheduler_top] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_left);
    $display("[periodic_task_tick_scheduler_top] ERROR");
    $finish;
  end

endmodule
